// ===== rtl/core/dro_pkg.sv =====
// ----------------------------------------------------------------------------
// dro_pkg
// Shared types, constants and calendar helpers for the daylight saving
// offset calculator.
// ----------------------------------------------------------------------------
package dro_pkg;

  localparam int unsigned UtcW    = 33;
  localparam int unsigned OffW    = 11;
  localparam int unsigned SumW    = 8;
  localparam int unsigned LocW    = 35;
  localparam int unsigned NxtW    = 34;
  localparam int unsigned DayW    = 17;
  localparam int unsigned YearW   = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 11;

  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned OutDepthDef   = 8;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegManual = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBase   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSummer = 2'd3;

  // Mode codes.
  localparam logic [1:0] ModeOff    = 2'd0;
  localparam logic [1:0] ModeAuto   = 2'd1;
  localparam logic [1:0] ModeManual = 2'd2;

  localparam logic signed [OffW-1:0] RuleBaseMin = 11'sd120;
  localparam logic [NxtW-1:0]        SecPerDay   = 34'd86400;
  localparam logic [NxtW-1:0]        StdShift    = 34'd7200;
  localparam logic [NxtW-1:0]        TransSec    = 34'd7200;

  // Reciprocals for the constant divisions.
  localparam logic [27:0] RecipDay675 = 28'd203613265;  // 2^37 / 675, rounded up
  localparam logic [18:0] RecipYear   = 19'd367468;     // 2^27 / 365.25
  localparam logic [17:0] RecipSeven  = 18'd149797;     // 2^20 / 7, rounded up

  typedef struct packed {
    logic [1:0]                mode;
    logic                      manual;
    logic signed [OffW-1:0]    base;
    logic signed [SumW-1:0]    summer;
  } cfg_t;

  typedef struct packed {
    logic [UtcW-1:0] utc;
    logic            rule;
    logic            fixed_on;
  } item_t;

  typedef struct packed {
    logic                      summer_active;
    logic signed [OffW-1:0]    local_offset_minutes;
    logic signed [LocW-1:0]    local_seconds;
    logic [NxtW-1:0]           next_change_utc;
    logic [NxtW-1:0]           next_change_wall;
  } res_t;

  // Leap year test for year 1970 + n, valid through 2299.
  function automatic logic is_leap(input logic [YearW-1:0] n);
    return (n[1:0] == 2'd2) && (n != 9'd130) && (n != 9'd230);
  endfunction

  // Day number of January 1st of year 1970 + n.
  function automatic logic [DayW-1:0] jan1(input logic [YearW-1:0] n);
    logic [9:0]  a;
    logic [15:0] b;
    logic [15:0] c;
    logic [DayW-1:0] lp4;
    logic [DayW-1:0] lp100;
    logic [DayW-1:0] lp400;
    a     = ({1'b0, n} + 10'd1) >> 2;
    b     = 16'(({1'b0, n} + 10'd69)) * 16'd41;
    c     = 16'(({1'b0, n} + 10'd369)) * 16'd41;
    lp4   = DayW'(a);
    lp100 = DayW'(b >> 12);
    lp400 = DayW'(c >> 14);
    return DayW'(DayW'(n) * 17'd365) + lp4 - lp100 + lp400;
  endfunction

endpackage

// ===== rtl/core/dro_fifo.sv =====
// ----------------------------------------------------------------------------
// dro_fifo
// Small first-word-fall-through queue on a register array.
// ----------------------------------------------------------------------------
module dro_fifo import dro_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/core/dro_front.sv =====
// ----------------------------------------------------------------------------
// dro_front
// Accepts queries and classifies them against the mode registers.
// ----------------------------------------------------------------------------
module dro_front import dro_pkg::*; (
  input  logic            push_i,
  input  logic            q_full_i,
  input  logic [UtcW-1:0] utc_i,
  input  cfg_t            cfg_i,
  output logic            q_wr_o,
  output item_t           item_o
);

  logic is_auto;

  // Mode 3 is treated as automatic.
  assign is_auto = (cfg_i.mode != ModeOff) && (cfg_i.mode != ModeManual);

  assign q_wr_o         = push_i && !q_full_i;
  assign item_o.utc      = utc_i;
  assign item_o.rule     = is_auto && (cfg_i.base == RuleBaseMin) &&
                           !cfg_i.summer[SumW-1] && (cfg_i.summer != '0);
  assign item_o.fixed_on = (cfg_i.mode == ModeManual) && cfg_i.manual;

endmodule

// ===== rtl/core/dro_back.sv =====
// ----------------------------------------------------------------------------
// dro_back
// Calendar pipeline: civil year, transition days, window check and offsets.
// ----------------------------------------------------------------------------
module dro_back import dro_pkg::*; #(
  parameter int unsigned OutDepth = OutDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_empty_i,
  input  item_t q_item_i,
  output logic  q_rd_o,
  input  logic  out_pop_i,
  output logic  out_wr_o,
  output res_t  out_res_o
);

  localparam int unsigned CredW = $clog2(OutDepth + 1);

  logic [CredW-1:0] cred_q, cred_d;
  logic             issue;
  logic [6:1]       v_q;

  item_t s1_it_q, s2_it_q, s3_it_q, s4_it_q, s5_it_q, s6_it_q;
  logic [54:0]     s1_prod_q;
  logic [DayW-1:0] s2_days_q;
  logic [35:0]     s2_prod_q;
  logic [YearW-1:0] s3_n_q;
  logic [DayW-1:0]  s3_jan_q;
  logic [DayW:0]    s4_x_q [3];
  logic [35:0]      s4_prod_q [3];
  logic [NxtW-1:0]  s5_sec_q [3];
  logic             s6_act_q;
  logic [NxtW-1:0]  s6_nu_q, s6_nw_q;

  // Credits count everything in the pipeline plus the output queue.
  assign issue  = !q_empty_i && ((cred_q < CredW'(OutDepth)) || out_pop_i);
  assign q_rd_o = issue;

  always_comb begin
    cred_d = cred_q;
    if (issue && !out_pop_i) begin
      cred_d = cred_q + 1'b1;
    end else if (!issue && out_pop_i) begin
      cred_d = cred_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
      v_q    <= '0;
    end else begin
      cred_q <= cred_d;
      v_q    <= {v_q[5:1], issue};
    end
  end

  // Stage 1: day count of standard local time.
  logic [NxtW-1:0] std_sec;
  assign std_sec = NxtW'(q_item_i.utc) + StdShift;

  always_ff @(posedge clk_i) begin
    s1_it_q   <= q_item_i;
    s1_prod_q <= 55'(std_sec[33:7]) * 55'(RecipDay675);
  end

  // Stage 2: rough year estimate.
  logic [DayW-1:0] days;
  assign days = s1_prod_q[53:37];

  always_ff @(posedge clk_i) begin
    s2_it_q   <= s1_it_q;
    s2_days_q <= days;
    s2_prod_q <= 36'(days) * 36'(RecipYear);
  end

  // Stage 3: correct the estimate against January 1st boundaries.
  logic [YearW-1:0] n0;
  logic [DayW-1:0]  j0, jp, jm;
  assign n0 = s2_prod_q[35:27];
  assign j0 = jan1(n0);
  assign jp = j0 + 17'd365 + DayW'(is_leap(n0));
  assign jm = j0 - 17'd365 - DayW'(is_leap(n0 - 1'b1));

  always_ff @(posedge clk_i) begin
    s3_it_q <= s2_it_q;
    if (s2_days_q < j0) begin
      s3_n_q   <= n0 - 1'b1;
      s3_jan_q <= jm;
    end else if (s2_days_q >= jp) begin
      s3_n_q   <= n0 + 1'b1;
      s3_jan_q <= jp;
    end else begin
      s3_n_q   <= n0;
      s3_jan_q <= j0;
    end
  end

  // Stage 4: month-end days and the weekday reduction products.
  logic            lp, lpn;
  logic [DayW-1:0] jn;
  logic [DayW:0]   x4 [3];
  assign lp  = is_leap(s3_n_q);
  assign lpn = is_leap(s3_n_q + 1'b1);
  assign jn  = s3_jan_q + 17'd365 + DayW'(lp);
  assign x4[0] = 18'(s3_jan_q + 17'd89 + DayW'(lp)) + 18'd4;
  assign x4[1] = 18'(s3_jan_q + 17'd303 + DayW'(lp)) + 18'd4;
  assign x4[2] = 18'(jn + 17'd89 + DayW'(lpn)) + 18'd4;

  always_ff @(posedge clk_i) begin
    s4_it_q <= s3_it_q;
    for (int i = 0; i < 3; i++) begin
      s4_x_q[i]    <= x4[i];
      s4_prod_q[i] <= 36'(x4[i]) * 36'(RecipSeven);
    end
  end

  // Stage 5: last Sunday or the Friday before, then midnight in seconds.
  logic [DayW:0]   q7 [3];
  logic [2:0]      r7 [3];
  logic [DayW-1:0] tday [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q7[i]   = 18'(s4_prod_q[i] >> 20);
      r7[i]   = 3'(s4_x_q[i] - 18'(q7[i] * 18'd7));
      tday[i] = DayW'(s4_x_q[i] - 18'd4 - 18'(r7[i]));
    end
    tday[0] = tday[0] - 17'd2;
    tday[2] = tday[2] - 17'd2;
  end

  always_ff @(posedge clk_i) begin
    s5_it_q <= s4_it_q;
    for (int i = 0; i < 3; i++) begin
      s5_sec_q[i] <= NxtW'(tday[i]) * SecPerDay;
    end
  end

  // Stage 6: window check and next transition.
  logic [12:0]     dst;
  logic [NxtW-1:0] e_utc, utc6;
  assign dst   = 13'(cfg_i.summer[SumW-2:0]) * 13'd60;
  assign e_utc = s5_sec_q[1] - NxtW'(dst);
  assign utc6  = NxtW'(s5_it_q.utc);

  always_ff @(posedge clk_i) begin
    s6_it_q <= s5_it_q;
    if (!s5_it_q.rule) begin
      s6_act_q <= s5_it_q.fixed_on;
      s6_nu_q  <= '0;
      s6_nw_q  <= '0;
    end else if (utc6 < s5_sec_q[0]) begin
      s6_act_q <= 1'b0;
      s6_nu_q  <= s5_sec_q[0];
      s6_nw_q  <= s5_sec_q[0] + TransSec;
    end else if (utc6 < e_utc) begin
      s6_act_q <= 1'b1;
      s6_nu_q  <= e_utc;
      s6_nw_q  <= s5_sec_q[1] + TransSec;
    end else begin
      s6_act_q <= 1'b0;
      s6_nu_q  <= s5_sec_q[2];
      s6_nw_q  <= s5_sec_q[2] + TransSec;
    end
  end

  // Offset with saturation, then local time.
  logic signed [11:0]     sum;
  logic signed [OffW-1:0] off;
  logic signed [17:0]     off60;
  always_comb begin
    sum = 12'(cfg_i.base) + (s6_act_q ? 12'(cfg_i.summer) : 12'sd0);
    if (sum > 12'sd1023) begin
      off = 11'sd1023;
    end else if (sum < -12'sd1024) begin
      off = -11'sd1024;
    end else begin
      off = OffW'(sum);
    end
    off60 = 18'(off) * 18'sd60;
  end

  assign out_wr_o                       = v_q[6];
  assign out_res_o.summer_active        = s6_act_q;
  assign out_res_o.local_offset_minutes = off;
  assign out_res_o.local_seconds        = $signed({2'b00, s6_it_q.utc}) + LocW'(off60);
  assign out_res_o.next_change_utc      = s6_nu_q;
  assign out_res_o.next_change_wall     = s6_nw_q;

endmodule

// ===== rtl/core/dst_rule_offset_calc_top.sv =====
// ----------------------------------------------------------------------------
// dst_rule_offset_calc_top
// Daylight saving offset calculator: local offset, local time and next
// transition for a UTC second count.
// ----------------------------------------------------------------------------
//  Channel   | Handshake          | Payload
//  query in  | push / full        | utc_seconds_i
//  result    | empty / pop        | summer_active_o .. next_change_wall_o
//  config    | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// One query is accepted per cycle while full is low; a result leaves the
// calendar pipeline after the query queue and the six pipeline stages.
// Reset loads mode automatic, manual flag off, base 120 and daylight 60.
// The pipeline never stalls: issue is gated by credits for the result queue,
// so holding pop low only fills the queues and then raises full.
// ----------------------------------------------------------------------------
module dst_rule_offset_calc_top import dro_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef,
  parameter int unsigned OutDepth   = OutDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [UtcW-1:0]        utc_seconds_i,
  output logic                   empty,
  input  logic                   pop,
  output logic                   summer_active_o,
  output logic signed [OffW-1:0] local_offset_minutes_o,
  output logic signed [LocW-1:0] local_seconds_o,
  output logic [NxtW-1:0]        next_change_utc_o,
  output logic [NxtW-1:0]        next_change_wall_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDatW-1:0]     cfg_wdata_i
);

  cfg_t  cfg_q;
  item_t f_item, q_item;
  res_t  b_res, o_res;
  logic  f_wr, q_empty, q_rd, b_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= ModeAuto;
      cfg_q.manual <= 1'b0;
      cfg_q.base   <= 11'sd120;
      cfg_q.summer <= 8'sd60;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:   cfg_q.mode   <= cfg_wdata_i[1:0];
        RegManual: cfg_q.manual <= cfg_wdata_i[0];
        RegBase:   cfg_q.base   <= cfg_wdata_i;
        RegSummer: cfg_q.summer <= cfg_wdata_i[SumW-1:0];
        default:   cfg_q.mode   <= cfg_q.mode;
      endcase
    end
  end

  dro_front u_front (
    .push_i   (push),
    .q_full_i (full),
    .utc_i    (utc_seconds_i),
    .cfg_i    (cfg_q),
    .q_wr_o   (f_wr),
    .item_o   (f_item)
  );

  dro_fifo #(
    .Depth (QueueDepth),
    .Width ($bits(item_t))
  ) u_mid_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (f_wr),
    .wr_data_i (f_item),
    .rd_en_i   (q_rd),
    .rd_data_o (q_item),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  dro_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_item_i  (q_item),
    .q_rd_o    (q_rd),
    .out_pop_i (pop && !empty),
    .out_wr_o  (b_wr),
    .out_res_o (b_res)
  );

  dro_fifo #(
    .Depth (OutDepth),
    .Width ($bits(res_t))
  ) u_out_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (b_wr),
    .wr_data_i (b_res),
    .rd_en_i   (pop),
    .rd_data_o (o_res),
    .full_o    (),
    .empty_o   (empty)
  );

  assign summer_active_o        = o_res.summer_active;
  assign local_offset_minutes_o = o_res.local_offset_minutes;
  assign local_seconds_o        = o_res.local_seconds;
  assign next_change_utc_o      = o_res.next_change_utc;
  assign next_change_wall_o     = o_res.next_change_wall;

endmodule
